@@ design/vn_pkg.sv @@
package vn_pkg;

	localparam int COMP_W = 32;
	localparam int SQ_W = 63;
	localparam int SUM_W = 64;
	localparam int WIDE_W = 128;
	localparam int R_W = 31;
	localparam int NSTEP = 31;

	typedef struct packed {
		logic [WIDE_W-1:0] a;
		logic [WIDE_W-1:0] b;
		logic [R_W-1:0]    r;
	} step_t;

	// One step of the greedy search for the rounded unit magnitude r.
	// With u = 2r-1, a holds u*u*S and b holds u*S, so setting bit bp of r
	// updates both with shifts and adds only. The candidate is kept when
	// (2r-1)^2 * S <= m^2 * 2^62 and r has not already reached 1.0.
	function automatic step_t vn_step(input logic [WIDE_W-1:0] a, input logic [WIDE_W-1:0] b,
			input logic [SUM_W-1:0] s, input logic [SQ_W-1:0] sq,
			input logic [R_W-1:0] r, input int bp);
		logic [WIDE_W-1:0] s_w;
		logic [WIDE_W-1:0] ca;
		logic [WIDE_W-1:0] cb;
		logic [WIDE_W-1:0] rhs;
		step_t res;
		s_w = {{(WIDE_W-SUM_W){1'b0}}, s};
		ca = a + (b << (bp + 2)) + (s_w << (2 * bp + 2));
		cb = b + (s_w << (bp + 1));
		rhs = {{(WIDE_W-SQ_W-62){1'b0}}, sq, 62'b0};
		res.a = a;
		res.b = b;
		res.r = r;
		if (!r[R_W-1] && (ca <= rhs)) begin
			res.a = ca;
			res.b = cb;
			res.r = r | (R_W'(1) << bp);
		end
		return res;
	endfunction

endpackage

@@ design/vn_lane.sv @@
module vn_lane (
	input  logic                      clk,
	input  logic                      en,
	input  logic [vn_pkg::SUM_W-1:0]  s,
	input  logic [vn_pkg::SQ_W-1:0]   sq,
	output logic [vn_pkg::R_W-1:0]    r
);

	logic [vn_pkg::WIDE_W-1:0] a_s  [vn_pkg::NSTEP-1];
	logic [vn_pkg::WIDE_W-1:0] b_s  [vn_pkg::NSTEP-1];
	logic [vn_pkg::SUM_W-1:0]  s_s  [vn_pkg::NSTEP-1];
	logic [vn_pkg::SQ_W-1:0]   sq_s [vn_pkg::NSTEP-1];
	logic [vn_pkg::R_W-1:0]    r_s  [vn_pkg::NSTEP];
	vn_pkg::step_t             nxt  [vn_pkg::NSTEP];

	// Stage k decides bit (30 - k) of the result, most significant first.
	// The last stage only needs to keep the result bits.
	for (genvar k = 0; k < vn_pkg::NSTEP; k++) begin : g_step
		if (k == 0) begin : g_first
			always_comb begin
				nxt[k] = vn_pkg::vn_step({{(vn_pkg::WIDE_W-vn_pkg::SUM_W){1'b0}}, s},
					-{{(vn_pkg::WIDE_W-vn_pkg::SUM_W){1'b0}}, s}, s, sq, '0,
					vn_pkg::NSTEP - 1 - k);
			end
			always_ff @(posedge clk) begin
				if (en) begin
					s_s[k]  <= s;
					sq_s[k] <= sq;
				end
			end
		end else begin : g_next
			always_comb begin
				nxt[k] = vn_pkg::vn_step(a_s[k-1], b_s[k-1], s_s[k-1], sq_s[k-1], r_s[k-1],
					vn_pkg::NSTEP - 1 - k);
			end
			if (k < vn_pkg::NSTEP - 1) begin : g_pass
				always_ff @(posedge clk) begin
					if (en) begin
						s_s[k]  <= s_s[k-1];
						sq_s[k] <= sq_s[k-1];
					end
				end
			end
		end
		if (k < vn_pkg::NSTEP - 1) begin : g_acc
			always_ff @(posedge clk) begin
				if (en) begin
					a_s[k] <= nxt[k].a;
					b_s[k] <= nxt[k].b;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k] <= nxt[k].r;
			end
		end
	end

	assign r = r_s[vn_pkg::NSTEP-1];

endmodule

@@ design/vec3_normalize.sv @@
// An accepted input word passes every stage before its result word is offered.
// Throughput: one word per cycle; a stall at the output freezes the whole pipeline.
// The rounded unit magnitude is found by a 31-stage bit-per-stage search per component.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
module vec3_normalize (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // x_in [31:0], y_in [63:32], z_in [95:64]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // x_unit [31:0], y_unit [63:32], z_unit [95:64]
	output logic [0:0]  m_axis_tuser    // zero_length [0]
);

	// Total pipeline depth: three front stages, the search stages, and the output register.
	localparam int DEPTH = 3 + vn_pkg::NSTEP + 1;

	logic                     en;
	logic [DEPTH-1:0]         vld_q;

	// Stage 1: magnitudes and signs.
	logic [vn_pkg::COMP_W-1:0] mag_s1 [3];
	logic [2:0]                neg_s1;
	// Stage 2: squares. A magnitude of 2^31 squares to 2^62, so a square needs 63 bits.
	logic [vn_pkg::SQ_W-1:0]   sq_s2 [3];
	logic [2:0]                neg_s2;
	// Stage 3: sum of squares.
	logic [vn_pkg::SQ_W-1:0]   sq_s3 [3];
	logic [vn_pkg::SUM_W-1:0]  sum_s3;
	logic [2:0]                neg_s3;
	logic                      zero_s3;
	// Sign and zero flag ride beside the search stages.
	logic [2:0]                neg_p [vn_pkg::NSTEP];
	logic                      zero_p [vn_pkg::NSTEP];

	logic [vn_pkg::R_W-1:0]    r_lane [3];
	logic [95:0]               data_q;
	logic                      zero_q;

	// The pipeline moves whenever the output register is empty or being taken.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= s_axis_tdata[32*i+31];
				// Two's complement negate; the most negative value maps to 2^31.
				mag_s1[i] <= s_axis_tdata[32*i+31] ? (~s_axis_tdata[32*i +: 32] + 32'd1)
					: s_axis_tdata[32*i +: 32];
				sq_s2[i] <= vn_pkg::SQ_W'({32'b0, mag_s1[i]} * {32'b0, mag_s1[i]});
				sq_s3[i] <= sq_s2[i];
			end
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			// Three squares of at most 2^62 each fit in 64 bits.
			sum_s3 <= vn_pkg::SUM_W'(sq_s2[0]) + vn_pkg::SUM_W'(sq_s2[1])
				+ vn_pkg::SUM_W'(sq_s2[2]);
			zero_s3 <= (sq_s2[0] == '0) && (sq_s2[1] == '0) && (sq_s2[2] == '0);
			neg_p[0] <= neg_s3;
			zero_p[0] <= zero_s3;
			for (int k = 1; k < vn_pkg::NSTEP; k++) begin
				neg_p[k] <= neg_p[k-1];
				zero_p[k] <= zero_p[k-1];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vn_lane u_lane (
			.clk (clk),
			.en  (en),
			.s   (sum_s3),
			.sq  (sq_s3[i]),
			.r   (r_lane[i])
		);
	end

	// Output register: apply the sign, and force zeros for the zero vector.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_p[vn_pkg::NSTEP-1]) begin
					data_q[32*i +: 32] <= '0;
				end else if (neg_p[vn_pkg::NSTEP-1][i]) begin
					data_q[32*i +: 32] <= -{1'b0, r_lane[i]};
				end else begin
					data_q[32*i +: 32] <= {1'b0, r_lane[i]};
				end
			end
			zero_q <= zero_p[vn_pkg::NSTEP-1];
		end
	end

	assign m_axis_tvalid = vld_q[DEPTH-1];
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = zero_q;

endmodule

@@ design/vn_check.sv @@
module vn_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [95:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// A result word that is stalled stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	// The zero-vector flag comes with all-zero components.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("zero vector gave nonzero components");

	// Every component stays within [-1.0, 1.0].
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		($signed(m_axis_tdata[31:0]) >= -32'sd1073741824 &&
		 $signed(m_axis_tdata[31:0]) <= 32'sd1073741824 &&
		 $signed(m_axis_tdata[63:32]) >= -32'sd1073741824 &&
		 $signed(m_axis_tdata[63:32]) <= 32'sd1073741824 &&
		 $signed(m_axis_tdata[95:64]) >= -32'sd1073741824 &&
		 $signed(m_axis_tdata[95:64]) <= 32'sd1073741824))
		else $error("unit component out of range");

	// Input is taken exactly when the output side can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output flow");

endmodule

bind vec3_normalize vn_check u_vn_check (.*);

@@ bench/vec3_normalize_test.sv @@
`timescale 1ns / 1ps

module vec3_normalize_test;

	typedef struct packed {
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} vec_word_t;

	typedef struct {
		logic [31:0] x_unit;
		logic [31:0] y_unit;
		logic [31:0] z_unit;
		logic        zero_length;
	} unit_vec_t;

	localparam int NUM_RANDOM = 630;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;    // x_in [31:0], y_in [63:32], z_in [95:64]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;         // x_unit [31:0], y_unit [63:32], z_unit [95:64]
	logic [0:0]  m_axis_tuser;         // zero_length [0]

	// Ready as seen at the last rising edge, so the sender knows whether its
	// word was accepted.
	logic        s_axis_tready_q = 1'b0;

	vec_word_t pending_vecs[$];
	unit_vec_t expected_units[$];
	int        words_in = 0;
	int        total_words = 0;
	int        mismatches = 0;
	int        cycle_count = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;

	vec3_normalize uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	// Magnitude of a component, where -2^31 keeps its full size 2^31.
	function automatic logic [31:0] comp_mag(input logic [31:0] c);
		return c[31] ? (~c + 32'd1) : c;
	endfunction

	// Largest r in [0, 2^30] whose rounding threshold (2r-1)^2 * S stays at or
	// below m^2 * 2^62; this is m * 2^30 / sqrt(S) rounded to nearest.
	function automatic logic [31:0] rounded_unit_mag(input logic [31:0] m,
			input logic [63:0] s);
		logic [31:0]  lo;
		logic [31:0]  hi;
		logic [31:0]  mid;
		logic [63:0]  t;
		logic [127:0] lhs;
		logic [127:0] rhs;
		lo = 32'd0;
		hi = 32'h4000_0000;
		rhs = {64'd0, 64'(m) * 64'(m)} << 62;
		while (lo < hi) begin
			mid = lo + (hi - lo + 32'd1) / 2;
			t = 64'(mid) * 2 - 64'd1;
			lhs = {64'd0, t * t} * {64'd0, s};
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 32'd1;
			end
		end
		return lo;
	endfunction

	function automatic unit_vec_t normalize_vec(input vec_word_t v);
		unit_vec_t   u;
		logic [31:0] mx;
		logic [31:0] my;
		logic [31:0] mz;
		logic [63:0] s;
		mx = comp_mag(v.x);
		my = comp_mag(v.y);
		mz = comp_mag(v.z);
		s = 64'(mx) * mx + 64'(my) * my + 64'(mz) * mz;
		u.zero_length = (s == 64'd0);
		if (s == 64'd0) begin
			u.x_unit = '0;
			u.y_unit = '0;
			u.z_unit = '0;
		end else begin
			u.x_unit = rounded_unit_mag(mx, s);
			u.y_unit = rounded_unit_mag(my, s);
			u.z_unit = rounded_unit_mag(mz, s);
			if (v.x[31]) u.x_unit = -u.x_unit;
			if (v.y[31]) u.y_unit = -u.y_unit;
			if (v.z[31]) u.z_unit = -u.z_unit;
		end
		return u;
	endfunction

	// Idle rates: the sender idles with a chance of 22 in a hundred and the receiver 77
	// in the first third, the other way round in the second, none at the end.
	function automatic int phase_of(input int n);
		if (n < total_words / 3) return 0;
		if (n < (2 * total_words) / 3) return 1;
		return 2;
	endfunction

	// Sender: a new word goes out at the falling edge once the previous one was
	// taken. The valid flag is written once per edge.
	always @(negedge clk) begin
		int ph;
		bit idle;
		ph = phase_of(words_in);
		idle = (ph == 0) ? ($urandom_range(99) < 22) :
			(ph == 1) ? ($urandom_range(99) < 77) : 1'b0;
		if (arst_n && !(s_axis_tvalid && !s_axis_tready_q)) begin
			if (pending_vecs.size() != 0 && !idle) begin
				s_axis_tdata <= pending_vecs.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		s_axis_tready_q <= s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_units.push_back(normalize_vec(s_axis_tdata));
			words_in <= words_in + 1;
		end
	end

	// One long hold-off on the result side so the pipeline fills and the
	// input backs up while the sender keeps offering words.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && words_in >= 120) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(negedge clk) begin
		int ph;
		bit idle;
		ph = phase_of(words_in);
		idle = (ph == 0) ? ($urandom_range(99) < 77) :
			(ph == 1) ? ($urandom_range(99) < 22) : 1'b0;
		m_axis_tready <= arst_n && (hold_left == 0) && !idle;
	end

	// Result checker: each accepted word against the oldest expectation.
	always @(posedge clk) begin
		unit_vec_t exp_u;
		cycle_count <= cycle_count + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_units.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result word %h user %b", m_axis_tdata, m_axis_tuser);
			end else begin
				exp_u = expected_units.pop_front();
				if (m_axis_tdata[31:0] !== exp_u.x_unit ||
						m_axis_tdata[63:32] !== exp_u.y_unit ||
						m_axis_tdata[95:64] !== exp_u.z_unit ||
						m_axis_tuser[0] !== exp_u.zero_length) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected x %h y %h z %h zero %b, got x %h y %h z %h zero %b",
							exp_u.x_unit, exp_u.y_unit, exp_u.z_unit, exp_u.zero_length,
							m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
							m_axis_tuser[0]);
				end
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("vec3_normalize_test NOT OK");
			$finish;
		end
	end

	task automatic add_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		vec_word_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		pending_vecs.push_back(v);
	endtask

	function automatic logic [31:0] rand_comp(input int shift);
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) return 32'd0;
		if (pick == 1) return 32'h8000_0000;
		if (pick == 2) return 32'h7FFF_FFFF;
		return $signed($urandom()) >>> shift;
	endfunction

	initial begin
		int shift;
		// Directed: zero vector, single axes, extremes, most negative values.
		add_vec(32'd0, 32'd0, 32'd0);
		add_vec(32'd1, 32'd0, 32'd0);
		add_vec(32'd0, -32'd1, 32'd0);
		add_vec(32'd0, 32'd0, 32'h8000_0000);
		add_vec(32'h7FFF_FFFF, 32'd0, 32'd0);
		add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		add_vec(32'd1, 32'd1, 32'd1);
		add_vec(-32'd1, -32'd1, -32'd1);
		add_vec(32'd3, 32'd4, 32'd0);
		add_vec(32'd2, -32'd1, 32'd2);
		add_vec(32'd1, 32'h7FFF_FFFF, 32'd1);
		add_vec(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF);
		add_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'd0);
		add_vec(32'd0, 32'd0, 32'd0);
		add_vec(32'd1, 32'd2, 32'd3);
		add_vec(32'h8000_0000, 32'd1, 32'd0);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			shift = $urandom_range(31);
			add_vec(rand_comp(shift), rand_comp(shift), rand_comp(shift));
		end
		total_words = pending_vecs.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (words_in == total_words);
		wait (expected_units.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_units.size() == 0) begin
			$display("vec3_normalize_test OK");
		end else begin
			$display("vec3_normalize_test NOT OK");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/vn_pkg.sv
design/vn_lane.sv
design/vec3_normalize.sv
design/vn_check.sv
bench/vec3_normalize_test.sv
